>>> hdl/ssmalu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ssmalu_pkg
// Shared types and constants for the sign-magnitude saturating ALU.
// ============================================================================
package ssmalu_pkg;

    localparam int FIELD_WIDTH   = 64;
    localparam int MAG_WIDTH_DEF = 64;
    localparam int OP_WIDTH      = 3;
    localparam int ORD_WIDTH     = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_NEGATE  = 3'd2,
        OP_COMPARE = 3'd3,
        OP_CONVERT = 3'd4
    } t_op;

    typedef enum logic [ORD_WIDTH-1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_ord;

endpackage

>>> hdl/ssmalu_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ssmalu_if
// Operand and result channels of the sign-magnitude saturating ALU.
// ============================================================================
interface ssmalu_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [ssmalu_pkg::OP_WIDTH-1:0]        operation;
    logic                                   a_neg;
    logic                                   a_inf;
    logic [ssmalu_pkg::FIELD_WIDTH-1:0]     a_mag;
    logic                                   b_neg;
    logic                                   b_inf;
    logic [ssmalu_pkg::FIELD_WIDTH-1:0]     b_mag;

    modport source (output valid, operation, a_neg, a_inf, a_mag, b_neg, b_inf, b_mag,
                    input ready);
    modport sink   (input valid, operation, a_neg, a_inf, a_mag, b_neg, b_inf, b_mag,
                    output ready);
endinterface

interface ssmalu_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   r_neg;
    logic                                   r_inf;
    logic [ssmalu_pkg::FIELD_WIDTH-1:0]     r_mag;
    logic [ssmalu_pkg::ORD_WIDTH-1:0]       order;
    logic                                   identical;

    modport source (output valid, r_neg, r_inf, r_mag, order, identical, input ready);
    modport sink   (input valid, r_neg, r_inf, r_mag, order, identical, output ready);
endinterface

>>> hdl/saturating_sign_magnitude_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// saturating_sign_magnitude_alu
// Three-stage pipelined add, subtract, negate, compare and convert on
// sign / infinity / magnitude numbers, with saturation to infinity.
//
// Usage:
//   i_in carries one operation and two operands per beat; o_out carries one
//   result per beat. Both use valid/ready; a beat moves when both are high.
//   Throughput: one beat per cycle, sustained, with o_out.ready held high.
//   An accepted input beat is registered in stage 1, stage 2 and stage 3 in turn, and o_out.valid is stage 3's valid.
//   Stage 1 decodes the operation, conditions the right operand for
//   subtract and negates a negative word for convert; stage 2 runs the magnitude
//   adder and subtractor; stage 3 selects the result into the output register.
//   Each stage holds its beat while the next is full and stalled, so a stall
//   on o_out backs up stage by stage and i_in.ready drops only once all three
//   stages are full. Nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline; the block is
//   ready to accept in the first cycle after reset.
//   Only the low MAG_WIDTH bits of the magnitudes are used; r_mag is
//   zero-extended to 64 bits.
// ============================================================================
module saturating_sign_magnitude_alu #(
    parameter int MAG_WIDTH = ssmalu_pkg::MAG_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ssmalu_in_if.sink    i_in,
    ssmalu_out_if.source o_out
);

    localparam int MW = MAG_WIDTH;

    // pipeline control
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3     = !r_v3 || o_out.ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: decode
    // ------------------------------------------------------------------
    ssmalu_pkg::t_op n_s1_op, r_s1_op;
    logic            n_s1_a_neg, r_s1_a_neg;
    logic            n_s1_a_inf, r_s1_a_inf;
    logic [MW-1:0]   n_s1_a_mag, r_s1_a_mag;
    logic            n_s1_b_neg, r_s1_b_neg;
    logic            r_s1_b_inf;
    logic [MW-1:0]   r_s1_b_mag;
    logic [MW-1:0]   w_word;
    logic [MW-1:0]   w_bmag;

    assign w_word = i_in.a_mag[MW-1:0];
    assign w_bmag = i_in.b_mag[MW-1:0];

    always_comb begin
        n_s1_op    = ssmalu_pkg::t_op'(i_in.operation);
        n_s1_a_neg = i_in.a_neg;
        n_s1_a_inf = i_in.a_inf;
        n_s1_a_mag = w_word;
        n_s1_b_neg = i_in.b_neg;
        unique case (n_s1_op)
            ssmalu_pkg::OP_SUB: begin
                if (!i_in.b_inf && (w_bmag == '0)) n_s1_b_neg = 1'b0;
                else                               n_s1_b_neg = !i_in.b_neg;
            end
            ssmalu_pkg::OP_CONVERT: begin
                n_s1_a_neg = w_word[MW-1];
                n_s1_a_inf = 1'b0;
                n_s1_a_mag = w_word[MW-1] ? MW'(~w_word + MW'(1)) : w_word;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in.valid) begin
            r_s1_op    <= n_s1_op;
            r_s1_a_neg <= n_s1_a_neg;
            r_s1_a_inf <= n_s1_a_inf;
            r_s1_a_mag <= n_s1_a_mag;
            r_s1_b_neg <= n_s1_b_neg;
            r_s1_b_inf <= i_in.b_inf;
            r_s1_b_mag <= w_bmag;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitude add, subtract, equality
    // ------------------------------------------------------------------
    ssmalu_pkg::t_op r_s2_op;
    logic            r_s2_a_neg, r_s2_a_inf, r_s2_b_neg, r_s2_b_inf;
    logic [MW-1:0]   r_s2_a_mag;
    logic [MW:0]     n_s2_sum, r_s2_sum;
    logic [MW:0]     n_s2_diff, r_s2_diff;
    logic            n_s2_eq, r_s2_eq;
    logic            n_s2_same, r_s2_same;

    always_comb begin
        n_s2_sum  = {1'b0, r_s1_a_mag} + {1'b0, r_s1_b_mag};
        n_s2_diff = {1'b0, r_s1_a_mag} - {1'b0, r_s1_b_mag};
        n_s2_eq   = (r_s1_a_mag == r_s1_b_mag);
        n_s2_same = n_s2_eq && (r_s1_a_neg == r_s1_b_neg) && (r_s1_a_inf == r_s1_b_inf);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2_op    <= r_s1_op;
            r_s2_a_neg <= r_s1_a_neg;
            r_s2_a_inf <= r_s1_a_inf;
            r_s2_b_neg <= r_s1_b_neg;
            r_s2_b_inf <= r_s1_b_inf;
            r_s2_a_mag <= r_s1_a_mag;
            r_s2_sum   <= n_s2_sum;
            r_s2_diff  <= n_s2_diff;
            r_s2_eq    <= n_s2_eq;
            r_s2_same  <= n_s2_same;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: result select into output register
    // ------------------------------------------------------------------
    logic             n_neg, r_neg;
    logic             n_inf, r_inf;
    logic [MW-1:0]    n_mag, r_mag;
    ssmalu_pkg::t_ord n_ord, r_ord;
    logic             n_ident, r_ident;
    logic             w_borrow;

    assign w_borrow = r_s2_diff[MW];

    always_comb begin
        n_neg   = 1'b0;
        n_inf   = 1'b0;
        n_mag   = '0;
        n_ord   = ssmalu_pkg::ORD_LESS;
        n_ident = 1'b0;
        unique case (r_s2_op)
            ssmalu_pkg::OP_ADD, ssmalu_pkg::OP_SUB: begin
                if (r_s2_a_inf) begin
                    n_neg = r_s2_a_neg;
                    n_inf = 1'b1;
                end else if (r_s2_b_inf) begin
                    n_neg = r_s2_b_neg;
                    n_inf = 1'b1;
                end else if (r_s2_a_neg == r_s2_b_neg) begin
                    n_neg = r_s2_a_neg;
                    if (r_s2_sum[MW]) n_inf = 1'b1;
                    else              n_mag = r_s2_sum[MW-1:0];
                end else if (r_s2_eq) begin
                    n_neg = 1'b0;
                end else if (!w_borrow) begin
                    n_neg = r_s2_a_neg;
                    n_mag = r_s2_diff[MW-1:0];
                end else begin
                    n_neg = r_s2_b_neg;
                    n_mag = MW'(~r_s2_diff[MW-1:0] + MW'(1));
                end
            end
            ssmalu_pkg::OP_NEGATE: begin
                n_neg = r_s2_a_inf ? r_s2_a_neg : !r_s2_a_neg;
                n_inf = r_s2_a_inf;
                n_mag = r_s2_a_inf ? '0 : r_s2_a_mag;
            end
            ssmalu_pkg::OP_COMPARE: begin
                n_ident = r_s2_same;
                priority if (r_s2_a_inf && r_s2_b_inf) begin
                    if (r_s2_a_neg == r_s2_b_neg) n_ord = ssmalu_pkg::ORD_EQUAL;
                    else if (r_s2_a_neg)          n_ord = ssmalu_pkg::ORD_LESS;
                    else                          n_ord = ssmalu_pkg::ORD_GREATER;
                end else if (r_s2_a_inf) begin
                    n_ord = r_s2_a_neg ? ssmalu_pkg::ORD_LESS : ssmalu_pkg::ORD_GREATER;
                end else if (r_s2_b_inf) begin
                    n_ord = r_s2_b_neg ? ssmalu_pkg::ORD_GREATER : ssmalu_pkg::ORD_LESS;
                end else if (r_s2_a_neg != r_s2_b_neg) begin
                    n_ord = r_s2_a_neg ? ssmalu_pkg::ORD_LESS : ssmalu_pkg::ORD_GREATER;
                end else if (r_s2_eq) begin
                    n_ord = ssmalu_pkg::ORD_EQUAL;
                end else if (!r_s2_a_neg) begin
                    n_ord = w_borrow ? ssmalu_pkg::ORD_LESS : ssmalu_pkg::ORD_GREATER;
                end else begin
                    n_ord = w_borrow ? ssmalu_pkg::ORD_GREATER : ssmalu_pkg::ORD_LESS;
                end
            end
            ssmalu_pkg::OP_CONVERT: begin
                n_neg = r_s2_a_neg;
                n_mag = r_s2_a_mag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_neg   <= n_neg;
            r_inf   <= n_inf;
            r_mag   <= n_mag;
            r_ord   <= n_ord;
            r_ident <= n_ident;
        end
    end

    assign o_out.valid     = r_v3;
    assign o_out.r_neg     = r_neg;
    assign o_out.r_inf     = r_inf;
    assign o_out.r_mag     = ssmalu_pkg::FIELD_WIDTH'(r_mag);
    assign o_out.order     = r_ord;
    assign o_out.identical = r_ident;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_empty_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !r_v1 && !r_v2 && !r_v3) |-> ##3 o_out.valid)
        else $error("beat into empty pipeline did not reach output in three cycles");

    a_inf_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.r_inf) |-> (o_out.r_mag == '0))
        else $error("infinite result with nonzero magnitude");

    a_ident_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.identical) |-> (o_out.order == ssmalu_pkg::ORD_EQUAL))
        else $error("identical operands not ordered equal");

    a_order_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.order != ssmalu_pkg::ORD_LESS))
            |-> (!o_out.r_neg && !o_out.r_inf && (o_out.r_mag == '0)))
        else $error("compare result carries a number");

endmodule
